// ----- design/lfu_pkg.sv -----
// Shared types, constants and the control store for the LFU slot replacement block.
// Used by the sequencer, the datapath, the top level and the port checker.
package lfu_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF    = 16;
    localparam int ID_WIDTH_DEF = 8;

    // Fixed field widths
    localparam int CFG_W     = 5;
    localparam int CAND_W    = 8;
    localparam int IDX_W     = 4;
    localparam int COUNT_W   = 16;
    localparam int ID_OUT_W  = 8;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    // Output tuser bit positions
    localparam int U_HIT   = 0;
    localparam int U_EVICT = 1;
    localparam int U_SLOT  = 2;

    localparam logic [CFG_W-1:0]   ACTIVE_SLOTS_RST = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    // Operation codes
    localparam logic OP_REF  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Control store addresses
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t ST_IDLE       = 4'd0;
    localparam pc_t ST_DISP       = 4'd1;
    localparam pc_t ST_SCAN_RD    = 4'd2;
    localparam pc_t ST_SCAN_CMP   = 4'd3;
    localparam pc_t ST_HIT        = 4'd4;
    localparam pc_t ST_DECIDE     = 4'd5;
    localparam pc_t ST_EVICT      = 4'd6;
    localparam pc_t ST_SHIFT_RD   = 4'd7;
    localparam pc_t ST_SHIFT_WR   = 4'd8;
    localparam pc_t ST_SHIFT_DONE = 4'd9;
    localparam pc_t ST_APPEND     = 4'd10;
    localparam pc_t ST_RD_SLOT    = 4'd11;
    localparam pc_t ST_RD_RES     = 4'd12;
    localparam pc_t ST_FINISH     = 4'd13;
    localparam pc_t ST_HOLD       = 4'd14;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_P1,
        RA_SIDX
    } ra_sel_t;

    typedef enum logic [1:0] {
        WR_HIT,
        WR_SHIFT,
        WR_APPEND
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD,
        IDX_SCAN,
        IDX_INC,
        IDX_VICTIM
    } idx_op_t;

    typedef enum logic [1:0] {
        FILL_HOLD,
        FILL_DEC,
        FILL_INC
    } fill_op_t;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_READ,
        RES_HIT,
        RES_MISS
    } res_op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_BEAT,
        C_OP_READ,
        C_IDX_AT_FILL,
        C_NO_MATCH,
        C_NOT_FULL,
        C_SHIFT_END,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic     in_rdy;
        logic     rd_en;
        ra_sel_t  ra_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        idx_op_t  idx_op;
        fill_op_t fill_op;
        res_op_t  res_op;
        logic     ld_out;
        cond_t    cond;
        pc_t      target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_beat;
        logic op_read;
        logic idx_at_fill;
        logic no_match;
        logic not_full;
        logic shift_end;
        logic out_free;
    } status_t;

    localparam ctrl_word_t CW_NOP = '{
        in_rdy:  1'b0,
        rd_en:   1'b0,
        ra_sel:  RA_IDX,
        wr_en:   1'b0,
        wr_sel:  WR_HIT,
        idx_op:  IDX_HOLD,
        fill_op: FILL_HOLD,
        res_op:  RES_HOLD,
        ld_out:  1'b0,
        cond:    C_NEXT,
        target:  ST_IDLE
    };

    // Control store: a step falls through to the next address unless its
    // condition holds, in which case it jumps to target.
    function automatic ctrl_word_t lfu_ucode(input pc_t pc);
        ctrl_word_t cw;
        cw = CW_NOP;
        case (pc)
            ST_IDLE:
            begin
                cw.in_rdy = 1'b1;
                cw.idx_op = IDX_LOAD;
                cw.cond   = C_NO_BEAT;
                cw.target = ST_IDLE;
            end
            ST_DISP:
            begin
                cw.cond   = C_OP_READ;
                cw.target = ST_RD_SLOT;
            end
            ST_SCAN_RD:
            begin
                cw.rd_en  = 1'b1;
                cw.ra_sel = RA_IDX;
                cw.cond   = C_IDX_AT_FILL;
                cw.target = ST_DECIDE;
            end
            ST_SCAN_CMP:
            begin
                cw.idx_op = IDX_SCAN;
                cw.cond   = C_NO_MATCH;
                cw.target = ST_SCAN_RD;
            end
            ST_HIT:
            begin
                cw.wr_en  = 1'b1;
                cw.wr_sel = WR_HIT;
                cw.res_op = RES_HIT;
                cw.cond   = C_ALWAYS;
                cw.target = ST_FINISH;
            end
            ST_DECIDE:
            begin
                cw.cond   = C_NOT_FULL;
                cw.target = ST_APPEND;
            end
            ST_EVICT:
            begin
                cw.idx_op = IDX_VICTIM;
            end
            ST_SHIFT_RD:
            begin
                cw.rd_en  = 1'b1;
                cw.ra_sel = RA_IDX_P1;
                cw.cond   = C_SHIFT_END;
                cw.target = ST_SHIFT_DONE;
            end
            ST_SHIFT_WR:
            begin
                cw.wr_en  = 1'b1;
                cw.wr_sel = WR_SHIFT;
                cw.idx_op = IDX_INC;
                cw.cond   = C_ALWAYS;
                cw.target = ST_SHIFT_RD;
            end
            ST_SHIFT_DONE:
            begin
                cw.fill_op = FILL_DEC;
            end
            ST_APPEND:
            begin
                cw.wr_en   = 1'b1;
                cw.wr_sel  = WR_APPEND;
                cw.fill_op = FILL_INC;
                cw.res_op  = RES_MISS;
                cw.cond    = C_ALWAYS;
                cw.target  = ST_FINISH;
            end
            ST_RD_SLOT:
            begin
                cw.rd_en  = 1'b1;
                cw.ra_sel = RA_SIDX;
            end
            ST_RD_RES:
            begin
                cw.res_op = RES_READ;
            end
            ST_FINISH:
            begin
                cw.ld_out = 1'b1;
                cw.cond   = C_OUT_FREE;
                cw.target = ST_IDLE;
            end
            ST_HOLD:
            begin
                cw.cond   = C_ALWAYS;
                cw.target = ST_FINISH;
            end
            default:
            begin
                cw.cond   = C_ALWAYS;
                cw.target = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ----- design/lfu_useq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on lfu_pkg for the control word, status flags and lfu_ucode.
module lfu_useq
    import lfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  status_t    status,
    output ctrl_word_t ctrl
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign ctrl = lfu_ucode(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NEXT:        take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_BEAT:     take = status.no_beat;
            C_OP_READ:     take = status.op_read;
            C_IDX_AT_FILL: take = status.idx_at_fill;
            C_NO_MATCH:    take = status.no_match;
            C_NOT_FULL:    take = status.not_full;
            C_SHIFT_END:   take = status.shift_end;
            C_OUT_FREE:    take = status.out_free;
            default:       take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- design/lfu_dpath.sv -----
// Datapath: slot memory, index and fill counters, minimum tracker, result and
// output registers, config register. Steered by the control word; depends on lfu_pkg.
module lfu_dpath
    import lfu_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_word_t            ctrl,
    output status_t               status,
    input  logic                  s_axis_tvalid,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int AW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);
    localparam int EW = ID_WIDTH + COUNT_W;
    localparam int XW = (FW > IDX_W) ? FW : IDX_W;
    localparam int LW = (FW > CFG_W) ? FW : CFG_W;

    // Slot store, oldest entry at address 0: {id, count}
    logic [EW-1:0] entry_mem [SLOTS];
    logic [EW-1:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;

    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [CFG_W-1:0] active_slots_reg;

    logic                opcode_reg;
    logic [ID_WIDTH-1:0] cand_reg;
    logic [IDX_W-1:0]    sidx_reg;

    logic [COUNT_W-1:0]  min_count_reg;
    logic [FW-1:0]       victim_reg;
    logic [ID_WIDTH-1:0] victim_id_reg;
    logic                ev_valid_reg;
    logic [ID_WIDTH-1:0] ev_id_reg;

    logic                res_hit_reg;
    logic                res_ev_valid_reg;
    logic [ID_WIDTH-1:0] res_ev_id_reg;
    logic                res_slot_valid_reg;
    logic [ID_WIDTH-1:0] res_slot_id_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    logic [ID_WIDTH-1:0] rd_id;
    logic [COUNT_W-1:0]  rd_count;
    logic [COUNT_W-1:0]  count_inc;
    logic                match;
    logic                accept;
    logic                sidx_ok;
    logic [LW-1:0]       limit;
    logic                out_free;

    assign rd_id     = rdata_reg[EW-1:COUNT_W];
    assign rd_count  = rdata_reg[COUNT_W-1:0];
    assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);
    assign match     = (rd_id == cand_reg);
    assign accept    = ctrl.in_rdy && s_axis_tvalid;
    assign sidx_ok   = XW'(sidx_reg) < XW'(fill_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Clamp the configured limit into 1..SLOTS
    always_comb
    begin
        if (active_slots_reg == '0)
        begin
            limit = LW'(1);
        end
        else if (LW'(active_slots_reg) > LW'(SLOTS))
        begin
            limit = LW'(SLOTS);
        end
        else
        begin
            limit = LW'(active_slots_reg);
        end
    end

    always_comb
    begin
        status.no_beat     = !s_axis_tvalid;
        status.op_read     = (opcode_reg == OP_READ);
        status.idx_at_fill = (idx_reg == fill_reg);
        status.no_match    = !match;
        status.not_full    = LW'(fill_reg) < limit;
        status.shift_end   = ((FW+1)'(idx_reg) + (FW+1)'(1)) >= (FW+1)'(fill_reg);
        status.out_free    = out_free;
    end

    always_comb
    begin
        case (ctrl.ra_sel)
            RA_IDX:    raddr = AW'(idx_reg);
            RA_IDX_P1: raddr = AW'(idx_reg + FW'(1));
            RA_SIDX:   raddr = AW'(sidx_reg);
            default:   raddr = AW'(idx_reg);
        endcase
    end

    always_comb
    begin
        case (ctrl.wr_sel)
            WR_HIT:
            begin
                waddr = AW'(idx_reg);
                wdata = {rd_id, count_inc};
            end
            WR_SHIFT:
            begin
                waddr = AW'(idx_reg);
                wdata = rdata_reg;
            end
            WR_APPEND:
            begin
                waddr = AW'(fill_reg);
                wdata = {cand_reg, COUNT_W'(1)};
            end
            default:
            begin
                waddr = AW'(idx_reg);
                wdata = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= entry_mem[raddr];
        end
        if (ctrl.wr_en)
        begin
            entry_mem[waddr] <= wdata;
        end
    end

    always_comb
    begin
        case (ctrl.idx_op)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_LOAD:   idx_next = '0;
            IDX_SCAN:   idx_next = match ? idx_reg : idx_reg + FW'(1);
            IDX_INC:    idx_next = idx_reg + FW'(1);
            IDX_VICTIM: idx_next = victim_reg;
            default:    idx_next = idx_reg;
        endcase
        case (ctrl.fill_op)
            FILL_HOLD: fill_next = fill_reg;
            FILL_DEC:  fill_next = fill_reg - FW'(1);
            FILL_INC:  fill_next = fill_reg + FW'(1);
            default:   fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg          <= '0;
            fill_reg         <= '0;
            active_slots_reg <= ACTIVE_SLOTS_RST;
            ev_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            fill_reg <= fill_next;
            if (cfg_valid)
            begin
                active_slots_reg <= cfg_data;
            end
            if (accept)
            begin
                ev_valid_reg <= 1'b0;
            end
            else if (ctrl.idx_op == IDX_VICTIM)
            begin
                ev_valid_reg <= 1'b1;
            end
            if (ctrl.ld_out && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= s_axis_tuser[0];
            cand_reg   <= ID_WIDTH'(s_axis_tdata[CAND_W-1:0]);
            sidx_reg   <= s_axis_tdata[CAND_W +: IDX_W];
            ev_id_reg  <= '0;
        end
        else if (ctrl.idx_op == IDX_VICTIM)
        begin
            ev_id_reg <= victim_id_reg;
        end

        // Track the lowest count; strict compare keeps the oldest on a tie
        if (ctrl.idx_op == IDX_SCAN)
        begin
            if (idx_reg == '0 || rd_count < min_count_reg)
            begin
                min_count_reg <= rd_count;
                victim_reg    <= idx_reg;
                victim_id_reg <= rd_id;
            end
        end

        case (ctrl.res_op)
            RES_HOLD:
            begin
            end
            RES_READ:
            begin
                res_hit_reg        <= 1'b0;
                res_ev_valid_reg   <= 1'b0;
                res_ev_id_reg      <= '0;
                res_slot_valid_reg <= sidx_ok;
                res_slot_id_reg    <= sidx_ok ? rd_id : '0;
                res_count_reg      <= sidx_ok ? rd_count : '0;
            end
            RES_HIT:
            begin
                res_hit_reg        <= 1'b1;
                res_ev_valid_reg   <= 1'b0;
                res_ev_id_reg      <= '0;
                res_slot_valid_reg <= 1'b1;
                res_slot_id_reg    <= cand_reg;
                res_count_reg      <= count_inc;
            end
            RES_MISS:
            begin
                res_hit_reg        <= 1'b0;
                res_ev_valid_reg   <= ev_valid_reg;
                res_ev_id_reg      <= ev_id_reg;
                res_slot_valid_reg <= 1'b1;
                res_slot_id_reg    <= cand_reg;
                res_count_reg      <= COUNT_W'(1);
            end
            default:
            begin
            end
        endcase

        if (ctrl.ld_out && out_free)
        begin
            out_data_reg <= {res_count_reg, ID_OUT_W'(res_slot_id_reg),
                             ID_OUT_W'(res_ev_id_reg)};
            out_user_reg <= {res_slot_valid_reg, res_ev_valid_reg, res_hit_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- design/lfu_slot_replacement.sv -----
// Top level of the LFU slot replacement block: microcode sequencer plus datapath.
// Depends on lfu_pkg, lfu_useq and lfu_dpath.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------------
//   s_axis   | in        | s_axis_tvalid/tready    | tdata: candidate, slot_index; tuser: opcode
//   m_axis   | out       | m_axis_tvalid/tready    | tdata: evicted_id, slot_id, slot_count;
//            |           |                         | tuser: hit, evicted_valid, slot_valid
//   cfg      | in        | cfg_valid/cfg_ready     | cfg_data: active_slots
//
// One beat is taken at a time. A read passes through the dispatch, slot read and
// result steps; a reference scans the held entries from slot 0 up to a match or to
// the fill level, and a miss then appends, first evicting the lowest-count entry and
// shifting down the entries above it when the block is full. The scan and the shift
// pair each slot read of the single read port with a compare or write step. The next
// beat is taken in the idle step. Reset empties the block at once (no clearing pass;
// contents at or beyond the fill level never reach a result). A result waiting in the output
// register does not stop the next beat being accepted; the block stalls only at its final step.
module lfu_slot_replacement
    import lfu_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] candidate, [11:8] slot_index, zero fill
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] evicted_id, [15:8] slot_id,
                                                  // [31:16] slot_count
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] hit, [1] evicted_valid, [2] slot_valid
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data        // active_slots
);

    ctrl_word_t ctrl;
    status_t    status;

    assign s_axis_tready = ctrl.in_rdy;
    assign cfg_ready     = 1'b1;

    lfu_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    lfu_dpath #(
        .SLOTS    (SLOTS),
        .ID_WIDTH (ID_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data)
    );

endmodule

// ----- design/lfu_checker.sv -----
// Port-level checks for lfu_slot_replacement, bound to the top level.
// Depends on lfu_pkg for field widths and tuser bit positions.
module lfu_checker
    import lfu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // A hit never evicts, and always reports a held entry with a nonzero count
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[U_HIT] |->
            !m_axis_tuser[U_EVICT] && m_axis_tuser[U_SLOT]
            && (m_axis_tdata[31:16] != 16'd0))
        else $error("hit beat with eviction or empty slot");

    // No eviction means a zero evicted id
    a_evict_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[U_EVICT] |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("evicted id set without eviction");

    // An empty slot reads as all zeros
    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[U_SLOT] |->
            (m_axis_tdata[31:8] == 24'd0) && !m_axis_tuser[U_HIT])
        else $error("empty slot with nonzero contents");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind lfu_slot_replacement lfu_checker u_lfu_checker (.*);

// ----- dv/tb_lfu_slot_replacement.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lfu_slot_replacement: LFU replacement with oldest-first tie break.
// Depends on lfu_pkg and the design; keeps its own slot table to predict every result beat.
module tb_lfu_slot_replacement;
    import lfu_pkg::*;

    localparam int NSLOTS         = SLOTS_DEF;
    // Slowest item is a miss with 16 held entries evicting slot 0, plus random sender
    // gaps and receiver stalls at 53 percent; the limit is set well above that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_CYCLES     = 150;

    typedef struct {
        logic        hit;
        logic        evicted_valid;
        logic [7:0]  evicted_id;
        logic        slot_valid;
        logic [7:0]  slot_id;
        logic [15:0] slot_count;
    } lfu_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] candidate, [11:8] slot_index, zero fill
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // [0] opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [7:0] evicted_id, [15:8] slot_id,
                                                // [31:16] slot_count
    logic [OUT_USER_W-1:0] m_axis_tuser;        // [0] hit, [1] evicted_valid, [2] slot_valid
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;

    // Predicted slot table
    logic [7:0]       held_id [NSLOTS];
    logic [15:0]      held_cnt [NSLOTS];
    int               held_fill;
    logic [CFG_W-1:0] active_slots_reg;

    lfu_result_t outcome_q [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic [7:0]  id_pool [24];

    lfu_slot_replacement DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Apply one access to the predicted table and return the result it produces.
    function automatic lfu_result_t lfu_access(logic op, logic [7:0] cand, logic [3:0] sidx);
        lfu_result_t r;
        int i;
        int pos;
        int victim;
        int lim;
        r = '{default: '0};
        if (op == OP_READ)
        begin
            if (int'(sidx) < held_fill)
            begin
                r.slot_valid = 1'b1;
                r.slot_id    = held_id[sidx];
                r.slot_count = held_cnt[sidx];
            end
        end
        else
        begin
            pos = -1;
            for (i = 0; i < held_fill; i++)
                if (pos < 0 && held_id[i] == cand)
                    pos = i;
            if (pos >= 0)
            begin
                r.hit = 1'b1;
                if (held_cnt[pos] != COUNT_MAX)
                    held_cnt[pos] = held_cnt[pos] + 16'd1;
                r.slot_count = held_cnt[pos];
            end
            else
            begin
                lim = int'(active_slots_reg);
                if (lim < 1)
                    lim = 1;
                if (lim > NSLOTS)
                    lim = NSLOTS;
                if (held_fill >= lim && held_fill > 0)
                begin
                    // lowest count wins, first position on a tie
                    victim = 0;
                    for (i = 1; i < held_fill; i++)
                        if (held_cnt[i] < held_cnt[victim])
                            victim = i;
                    r.evicted_valid = 1'b1;
                    r.evicted_id    = held_id[victim];
                    for (i = victim; i + 1 < held_fill; i++)
                    begin
                        held_id[i]  = held_id[i + 1];
                        held_cnt[i] = held_cnt[i + 1];
                    end
                    held_fill--;
                end
                held_id[held_fill]  = cand;
                held_cnt[held_fill] = 16'd1;
                held_fill++;
                r.slot_count = 16'd1;
            end
            r.slot_valid = 1'b1;
            r.slot_id    = cand;
        end
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin : check_results
        lfu_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result beat with no expectation pending: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("hit", want.hit, m_axis_tuser[U_HIT]);
                check_field("evicted_valid", want.evicted_valid, m_axis_tuser[U_EVICT]);
                check_field("evicted_id", want.evicted_id, m_axis_tdata[7:0]);
                check_field("slot_valid", want.slot_valid, m_axis_tuser[U_SLOT]);
                check_field("slot_id", want.slot_id, m_axis_tdata[15:8]);
                check_field("slot_count", want.slot_count, m_axis_tdata[31:16]);
            end
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // End the run when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_lfu_slot_replacement: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Call right after a rising edge; returns at the edge where the beat is taken.
    task automatic send_item(logic op, logic [7:0] cand, logic [3:0] sidx);
        lfu_result_t want;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, sidx, cand};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want      = lfu_access(op, cand, sidx);
        outcome_q = {outcome_q, want};
    endtask

    task automatic reference_id(logic [7:0] cand);
        send_item(OP_REF, cand, 4'($urandom_range(15)));
    endtask

    task automatic read_slot(logic [3:0] sidx);
        send_item(OP_READ, 8'($urandom_range(255)), sidx);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_active_slots(logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        active_slots_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_reads();
        read_slot(4'd0);
        read_slot(4'd15);
        wait_drained();
    endtask

    // One entry hit over and over; its count climbs by one a beat
    task automatic test_repeated_hits();
        int n;
        for (n = 0; n < 40; n++)
            reference_id(8'hC3);
        read_slot(4'd0);
        wait_drained();
    endtask

    task automatic test_directed_replacement();
        write_active_slots(5'd2);
        reference_id(8'h00);            // append into the free slot
        reference_id(8'hFF);            // evict the low-count entry
        reference_id(8'hFF);
        reference_id(8'h00);
        reference_id(8'h00);
        reference_id(8'h5A);
        write_active_slots(5'd3);
        reference_id(8'hA5);
        reference_id(8'h3C);            // tie on count: oldest goes
        read_slot(4'd0);
        read_slot(4'd1);
        read_slot(4'd2);
        read_slot(4'd3);                // beyond fill
        write_active_slots(5'd0);       // limit below fill: entries stay
        reference_id(8'h99);
        read_slot(4'd2);
        write_active_slots(5'd31);      // clamps to slot count
        reference_id(8'h01);
        reference_id(8'h80);
        read_slot(4'd15);
        write_active_slots(5'd17);
        reference_id(8'hFE);
        reference_id(8'h01);
        write_active_slots(5'd16);
        wait_drained();
    endtask

    task automatic test_random_traffic(int idle, int stall, logic [CFG_W-1:0] limit, int count);
        int n;
        int i;
        idle_pct  = idle;
        stall_pct = stall;
        write_active_slots(limit);
        for (i = 0; i < 24; i++)
            id_pool[i] = 8'($urandom_range(255));
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(39) == 0)
                wait_drained();
            if ($urandom_range(99) < 20)
                read_slot(4'($urandom_range(15)));
            else if ($urandom_range(99) < 80)
                reference_id(id_pool[$urandom_range(23)]);
            else
                reference_id(8'($urandom_range(255)));
        end
        wait_drained();
    endtask

    initial
    begin
        held_fill        = 0;
        active_slots_reg = ACTIVE_SLOTS_RST;
        for (int i = 0; i < NSLOTS; i++)
        begin
            held_id[i]  = '0;
            held_cnt[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_repeated_hits();
        test_directed_replacement();
        test_random_traffic(0, 0, 5'd8, 160);
        test_random_traffic(53, 0, 5'd31, 160);
        test_random_traffic(0, 53, 5'd1, 160);
        test_random_traffic(29, 29, 5'($urandom_range(31)), 160);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0 && outcome_q.size() == 0)
            $display("tb_lfu_slot_replacement: PASS");
        else
            $display("tb_lfu_slot_replacement: FAIL");
        $finish;
    end

endmodule

// ----- lfu_slot_replacement.f -----
design/lfu_pkg.sv
design/lfu_useq.sv
design/lfu_dpath.sv
design/lfu_slot_replacement.sv
design/lfu_checker.sv
dv/tb_lfu_slot_replacement.sv
